// ===== sv/htp_pkg.sv =====
// ----------------------------------------------------------------------------
// htp_pkg
// Shared types and constants of the hex table text parser.
// ----------------------------------------------------------------------------
package htp_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;

    localparam logic [5:0] LEN_CAP    = 6'd63;
    localparam logic [3:0] HEADER_LEN = 4'd7;
    localparam logic [3:0] HP_FAIL    = 4'd15;

    localparam int LINE_SLOTS  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LEN  = 3'd1;
    localparam logic [2:0] ST_BAD_HEX  = 3'd2;
    localparam logic [2:0] ST_NO_TABLE = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        MODE_SEARCH = 3'b001,
        MODE_TABLE  = 3'b010,
        MODE_DONE   = 3'b100
    } t_mode;

    typedef logic [LINE_SLOTS-1:0][7:0] t_vals;

    // one finished line and/or the closing status, front to back
    typedef struct packed {
        logic       has_line;
        logic       has_status;
        logic [2:0] status;
        logic [7:0] base;
        logic [4:0] count;
        t_vals      vals;
    } t_cmd;

    // {bad, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b10000;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0: r = 8'h70;
            3'd1: r = 8'h68;
            3'd2: r = 8'h79;
            3'd3: r = 8'h73;
            3'd4: r = 8'h69;
            3'd5: r = 8'h63;
            3'd6: r = 8'h73;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/htp_front.sv =====
// ----------------------------------------------------------------------------
// htp_front
// Per-byte line scanner: trimming, header search, hex decode, line verdicts.
// ----------------------------------------------------------------------------
module htp_front
    import htp_pkg::*;
#(
    parameter int TABLE_ENTRIES  = 256,
    parameter int BYTES_PER_LINE = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_final,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int DW = $clog2(TABLE_ENTRIES + 1);

    t_mode          r_mode, n_mode;
    logic [5:0]     r_cl, n_cl;
    logic [5:0]     r_ps, n_ps;
    logic           r_started, n_started;
    logic           r_comment, n_comment;
    logic [3:0]     r_hp, n_hp;
    logic [3:0]     r_hd, n_hd;
    logic           r_hexbad, n_hexbad;
    t_vals          r_vals, n_vals;
    logic [DW-1:0]  r_done, n_done;
    logic [2:0]     r_err, n_err;

    logic [6:0]     pos_sum;
    logic [5:0]     pos;
    logic [4:0]     hex;
    logic           active;
    logic           comment_eff;
    logic [DW-1:0]  rem;
    logic [4:0]     count;

    assign pos_sum = {1'b0, r_cl} + {1'b0, r_ps};
    assign pos     = (pos_sum > {1'b0, LEN_CAP}) ? LEN_CAP : pos_sum[5:0];
    assign hex     = hex_decode(i_byte);
    assign active  = (r_mode != MODE_DONE) && (r_err == ST_OK);
    assign rem     = DW'(TABLE_ENTRIES) - r_done;
    assign count   = (rem < DW'(BYTES_PER_LINE)) ? 5'(rem) : 5'(BYTES_PER_LINE);

    always_comb begin
        n_mode      = r_mode;
        n_cl        = r_cl;
        n_ps        = r_ps;
        n_started   = r_started;
        n_comment   = r_comment;
        n_hp        = r_hp;
        n_hd        = r_hd;
        n_hexbad    = r_hexbad;
        n_vals      = r_vals;
        n_done      = r_done;
        n_err       = r_err;
        comment_eff = r_comment;
        o_push      = 1'b0;
        o_cmd       = '0;

        if (i_accept) begin
            if (active) begin
                if (i_byte != CH_LF) begin
                    if (i_byte <= CH_SPACE) begin
                        if (r_started && r_ps != LEN_CAP) begin
                            n_ps = r_ps + 6'd1;
                        end
                    end else begin
                        comment_eff = r_comment | (!r_started && i_byte == CH_HASH);
                        n_started   = 1'b1;
                        n_comment   = comment_eff;
                        if (!comment_eff) begin
                            if (r_ps != 6'd0) begin
                                n_hexbad = 1'b1;
                            end
                            n_cl = (pos == LEN_CAP) ? LEN_CAP : pos + 6'd1;
                            n_ps = 6'd0;
                            if (pos < 6'(HEADER_LEN) && r_hp == pos[3:0]
                                && i_byte == header_char(pos[2:0])) begin
                                n_hp = pos[3:0] + 4'd1;
                            end else begin
                                n_hp = HP_FAIL;
                            end
                            if (pos < 6'(2 * BYTES_PER_LINE)) begin
                                if (hex[4]) begin
                                    n_hexbad = 1'b1;
                                end else if (!pos[0]) begin
                                    n_hd = hex[3:0];
                                end else begin
                                    n_vals[pos[4:1]] = {r_hd, hex[3:0]};
                                end
                            end
                        end
                    end
                end
                if (i_byte == CH_LF || i_final) begin
                    if (n_started && !n_comment) begin
                        case (r_mode)
                            MODE_TABLE: begin
                                if (r_done >= DW'(TABLE_ENTRIES)) begin
                                    n_mode = MODE_DONE;
                                end else if (n_cl != 6'(2 * BYTES_PER_LINE)) begin
                                    n_err = ST_BAD_LEN;
                                end else if (n_hexbad) begin
                                    n_err = ST_BAD_HEX;
                                end else begin
                                    o_cmd.has_line = 1'b1;
                                    o_cmd.base     = 8'(r_done);
                                    o_cmd.count    = count;
                                    o_cmd.vals     = n_vals;
                                    n_done         = r_done + DW'(count);
                                end
                            end
                            MODE_SEARCH: begin
                                if (n_cl == 6'(HEADER_LEN) && n_hp == HEADER_LEN) begin
                                    n_mode = MODE_TABLE;
                                end
                            end
                            default: ;
                        endcase
                    end
                    n_cl      = 6'd0;
                    n_ps      = 6'd0;
                    n_started = 1'b0;
                    n_comment = 1'b0;
                    n_hp      = 4'd0;
                    n_hd      = 4'd0;
                    n_hexbad  = 1'b0;
                end
            end
            if (i_final) begin
                o_cmd.has_status = 1'b1;
                if (n_err != ST_OK) begin
                    o_cmd.status = n_err;
                end else if (n_mode == MODE_SEARCH) begin
                    o_cmd.status = ST_NO_TABLE;
                end else if (n_done < DW'(TABLE_ENTRIES)) begin
                    o_cmd.status = ST_SHORT;
                end else begin
                    o_cmd.status = ST_OK;
                end
                n_mode    = MODE_SEARCH;
                n_cl      = 6'd0;
                n_ps      = 6'd0;
                n_started = 1'b0;
                n_comment = 1'b0;
                n_hp      = 4'd0;
                n_hd      = 4'd0;
                n_hexbad  = 1'b0;
                n_done    = '0;
                n_err     = ST_OK;
            end
            o_push = o_cmd.has_line | o_cmd.has_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_SEARCH;
            r_cl      <= 6'd0;
            r_ps      <= 6'd0;
            r_started <= 1'b0;
            r_comment <= 1'b0;
            r_hp      <= 4'd0;
            r_hd      <= 4'd0;
            r_hexbad  <= 1'b0;
            r_done    <= '0;
            r_err     <= ST_OK;
        end else begin
            r_mode    <= n_mode;
            r_cl      <= n_cl;
            r_ps      <= n_ps;
            r_started <= n_started;
            r_comment <= n_comment;
            r_hp      <= n_hp;
            r_hd      <= n_hd;
            r_hexbad  <= n_hexbad;
            r_done    <= n_done;
            r_err     <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vals <= n_vals;
    end

endmodule

// ===== sv/htp_queue.sv =====
// ----------------------------------------------------------------------------
// htp_queue
// Small command queue between the line scanner and the result sequencer.
// ----------------------------------------------------------------------------
module htp_queue
    import htp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/htp_back.sv =====
// ----------------------------------------------------------------------------
// htp_back
// Result sequencer: expands queued lines into byte beats, then the status.
// ----------------------------------------------------------------------------
module htp_back
    import htp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_data,
    output logic        o_user,
    output logic        o_last
);

    logic [4:0]  r_j, n_j;
    logic        r_valid, n_valid;
    logic [23:0] r_data, n_data;
    logic        r_user, n_user;
    logic        r_last, n_last;
    logic        out_ok;
    logic        byte_left;

    assign out_ok    = !r_valid || i_ready;
    assign byte_left = i_head.has_line && (r_j < i_head.count);

    always_comb begin
        o_pop   = 1'b0;
        n_j     = r_j;
        n_valid = r_valid & ~i_ready;
        n_data  = r_data;
        n_user  = r_user;
        n_last  = r_last;
        if (!i_empty && out_ok) begin
            n_valid = 1'b1;
            if (byte_left) begin
                n_user = KIND_BYTE;
                n_last = 1'b0;
                n_data = {5'b0, ST_OK, i_head.vals[r_j[3:0]], i_head.base + 8'(r_j)};
                n_j    = r_j + 5'd1;
                if (n_j == i_head.count && !i_head.has_status) begin
                    o_pop = 1'b1;
                    n_j   = 5'd0;
                end
            end else begin
                n_user = KIND_STATUS;
                n_last = 1'b1;
                n_data = {5'b0, i_head.status, 16'b0};
                o_pop  = 1'b1;
                n_j    = 5'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j     <= 5'd0;
            r_valid <= 1'b0;
        end else begin
            r_j     <= n_j;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_user <= n_user;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule

// ===== sv/hex_table_text_parser.sv =====
// ----------------------------------------------------------------------------
// hex_table_text_parser
// Parses a tilesheet text stream into indexed table bytes plus one status.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle while o_s_tready is high; a good line
//   drains as up to BYTES_PER_LINE output beats, a final beat adds one status beat.
// A line's first result beat passes the queue, then the output register.
// o_s_tready drops only while the 4-entry command queue is full.
// Reset: synchronous, active low; clears parse control, queue pointers, out valid.
// ----------------------------------------------------------------------------
module hex_table_text_parser
    import htp_pkg::*;
#(
    parameter int TABLE_ENTRIES  = 256,
    parameter int BYTES_PER_LINE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tlast,   // final_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] entry_index, [15:8] entry_value,
                                     // [18:16] status_code, [23:19] zero
    output logic        o_m_tuser,   // item_kind
    output logic        o_m_tlast    // run_end
);

    logic accept;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    t_cmd cmd;
    t_cmd head;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    htp_front #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .BYTES_PER_LINE (BYTES_PER_LINE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_final  (i_s_tlast),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    htp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    htp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_user  (o_m_tuser),
        .o_last  (o_m_tlast)
    );

endmodule

// ===== sv/htp_checker.sv =====
// ----------------------------------------------------------------------------
// htp_checker
// Port-level checks of the hex table text parser, bound to the top level.
// ----------------------------------------------------------------------------
module htp_checker
    import htp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output beat valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled output beat changed");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser == KIND_STATUS)))
        else $error("tlast and beat kind disagree");

    a_status_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_STATUS |->
            o_m_tdata[15:0] == 16'h0000 && o_m_tdata[23:19] == 5'b0
            && o_m_tdata[18:16] <= ST_SHORT)
        else $error("malformed status beat");

    a_byte_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_BYTE |-> o_m_tdata[23:16] == 8'h00)
        else $error("table byte beat carries a status");

endmodule

bind hex_table_text_parser htp_checker u_htp_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hex_table_text_parser: text files go in as byte
// beats, a scoreboard class tracks the parse and checks every output beat.
// ----------------------------------------------------------------------------
module tb;
    import htp_pkg::*;

    localparam int TABLE_ENTRIES  = 256;
    localparam int BYTES_PER_LINE = 16;
    localparam int HEX_CHARS      = 2 * BYTES_PER_LINE;
    localparam int ITEM_TARGET    = 470;

    typedef struct packed {
        logic       kind;
        logic [7:0] index;
        logic [7:0] value;
        logic [2:0] status;
        logic       last;
    } t_out_beat;

    typedef enum int {
        DEF_NONE,
        DEF_SHORT,
        DEF_LONG,
        DEF_BAD_DIGIT,
        DEF_GAP,
        DEF_LEN_AND_HEX,
        DEF_OVERLONG,
        DEF_WIDE_GAP
    } t_defect;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MASK,
        RX_RANDOM,
        RX_SLOW
    } t_rx_style;

    class tilesheet_checker;
        t_mode       mode;
        logic [5:0]  line_len;
        logic [5:0]  gap_len;
        logic        started;
        logic        comment;
        logic [3:0]  hdr_pos;
        logic [3:0]  hi_nib;
        logic        digit_bad;
        logic [7:0]  slot [LINE_SLOTS];
        logic [8:0]  entries;
        logic [2:0]  err;
        t_out_beat   due_beats [$];
        string       hdr_word = "physics";
        int          errors;
        int          n_text;
        int          n_files;
        int          n_bytes;
        int          n_status [5];

        function new();
            clear_all();
        endfunction

        function void clear_line();
            line_len  = 0;
            gap_len   = 0;
            started   = 0;
            comment   = 0;
            hdr_pos   = 0;
            hi_nib    = 0;
            digit_bad = 0;
        endfunction

        function void clear_all();
            mode = MODE_SEARCH;
            clear_line();
            foreach (slot[i]) slot[i] = 0;
            entries = 0;
            err = ST_OK;
        endfunction

        function int nibble(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        function void take_char(logic [7:0] c);
            int pos;
            int v;
            pos = int'(line_len) + int'(gap_len);
            if (pos > LEN_CAP) pos = LEN_CAP;
            if (gap_len != 0) digit_bad = 1;
            line_len = (pos + 1 > LEN_CAP) ? LEN_CAP : 6'(pos + 1);
            gap_len = 0;
            if (pos < HEADER_LEN && hdr_pos == pos && c == hdr_word[pos]) begin
                hdr_pos = 4'(pos + 1);
            end else begin
                hdr_pos = HP_FAIL;
            end
            if (pos < HEX_CHARS) begin
                v = nibble(c);
                if (v < 0) begin
                    digit_bad = 1;
                end else if (pos % 2 == 0) begin
                    hi_nib = 4'(v);
                end else begin
                    slot[pos / 2] = {hi_nib, 4'(v)};
                end
            end
        endfunction

        function void end_line();
            t_out_beat b;
            if (started && !comment) begin
                if (mode == MODE_TABLE) begin
                    if (entries >= TABLE_ENTRIES) begin
                        mode = MODE_DONE;
                    end else if (line_len != HEX_CHARS) begin
                        err = ST_BAD_LEN;
                    end else if (digit_bad) begin
                        err = ST_BAD_HEX;
                    end else begin
                        for (int i = 0; i < BYTES_PER_LINE; i++) begin
                            if (entries < TABLE_ENTRIES) begin
                                b.kind   = KIND_BYTE;
                                b.index  = entries[7:0];
                                b.value  = slot[i];
                                b.status = ST_OK;
                                b.last   = 1'b0;
                                due_beats.push_back(b);
                                entries++;
                            end
                        end
                    end
                end else if (mode == MODE_SEARCH) begin
                    if (line_len == HEADER_LEN && hdr_pos == HEADER_LEN) mode = MODE_TABLE;
                end
            end
            clear_line();
        endfunction

        function void take_text(logic [7:0] c, logic last);
            t_out_beat b;
            n_text++;
            if (mode != MODE_DONE && err == ST_OK) begin
                if (c != CH_LF) begin
                    if (c <= CH_SPACE) begin
                        if (started && gap_len < LEN_CAP) gap_len++;
                    end else begin
                        if (!started) begin
                            started = 1;
                            if (c == CH_HASH) comment = 1;
                        end
                        if (!comment) take_char(c);
                    end
                end
                if (c == CH_LF || last) end_line();
            end
            if (last) begin
                if (err != ST_OK) b.status = err;
                else if (mode == MODE_SEARCH) b.status = ST_NO_TABLE;
                else if (entries < TABLE_ENTRIES) b.status = ST_SHORT;
                else b.status = ST_OK;
                b.kind  = KIND_STATUS;
                b.index = 0;
                b.value = 0;
                b.last  = 1'b1;
                due_beats.push_back(b);
                n_files++;
                clear_all();
            end
        endfunction

        function void check_out(logic [23:0] data, logic kind, logic last);
            t_out_beat e;
            if (due_beats.size() == 0) begin
                $error("output beat with nothing due: tdata %h tuser %b tlast %b",
                       data, kind, last);
                errors++;
                return;
            end
            e = due_beats.pop_front();
            if (kind != e.kind) begin
                $error("item_kind expected %0d actual %0d", e.kind, kind);
                errors++;
            end
            if (data[7:0] != e.index) begin
                $error("entry_index expected %0d actual %0d", e.index, data[7:0]);
                errors++;
            end
            if (data[15:8] != e.value) begin
                $error("entry_value expected %h actual %h", e.value, data[15:8]);
                errors++;
            end
            if (data[18:16] != e.status) begin
                $error("status_code expected %0d actual %0d", e.status, data[18:16]);
                errors++;
            end
            if (last != e.last) begin
                $error("run_end expected %0d actual %0d", e.last, last);
                errors++;
            end
            if (data[23:19] != 0) begin
                $error("tdata pad expected 0 actual %h", data[23:19]);
                errors++;
            end
            if (e.kind == KIND_STATUS) n_status[e.status]++;
            else n_bytes++;
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;
    logic        i_s_tlast  = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    tilesheet_checker sb;
    logic [7:0]       text_q [$];
    int               burst_left = 0;
    int               beats_sent = 0;
    int               rx_cycle   = 0;
    t_rx_style        rx_style   = RX_OPEN;
    logic [7:0]       rx_mask    = 8'hFF;

    hex_table_text_parser #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .BYTES_PER_LINE (BYTES_PER_LINE)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rx_cycle % 97 == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_mask  = 8'($urandom_range(1, 255));
        end
        case (rx_style)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_MASK:   i_m_tready <= rx_mask[rx_cycle % 8];
            RX_RANDOM: i_m_tready <= ($urandom_range(0, 3) != 0);
            RX_SLOW:   i_m_tready <= ((rx_cycle % 11) < 3);
            default:   i_m_tready <= 1'b1;
        endcase
        rx_cycle++;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_out(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    // whitespace in the trimmed sense: anything up to 0x20 but LF
    function automatic logic [7:0] pick_ws();
        logic [7:0] c;
        c = 8'($urandom_range(0, 32));
        if (c == CH_LF) c = CH_SPACE;
        return c;
    endfunction

    function automatic logic [7:0] pick_hex();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10) return 8'("0" + k);
        if (k < 16) return 8'("a" + k - 10);
        return 8'("A" + k - 16);
    endfunction

    // byte above 0x20 that is not a hex digit
    function automatic logic [7:0] pick_bad();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(8'h21, 8'h2F));
            1:       return 8'($urandom_range(8'h3A, 8'h40));
            2:       return 8'($urandom_range(8'h47, 8'h60));
            default: return 8'($urandom_range(8'h67, 8'hFF));
        endcase
    endfunction

    function automatic void add_ws(int maxn);
        int n;
        n = $urandom_range(0, maxn);
        repeat (n) text_q.push_back(pick_ws());
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    function automatic void add_filler(bit allow_junk);
        int k;
        k = $urandom_range(0, allow_junk ? 2 : 1);
        add_ws(3);
        if (k == 1) begin
            text_q.push_back(CH_HASH);
            repeat ($urandom_range(0, 12)) begin
                text_q.push_back(($urandom_range(0, 3) == 0) ? pick_ws()
                                 : 8'($urandom_range(8'h21, 8'hFF)));
            end
        end else if (k == 2) begin
            repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(8'h21, 8'hFF)));
        end
        text_q.push_back(CH_LF);
    endfunction

    function automatic void add_header(bit mutate);
        add_ws(3);
        if (!mutate) begin
            add_text("physics");
        end else begin
            case ($urandom_range(0, 3))
                0:       add_text("physic");
                1:       add_text("physicsx");
                2:       add_text("Physics");
                default: add_text("phy sics");
            endcase
        end
        add_ws(3);
        text_q.push_back(CH_LF);
    endfunction

    function automatic void add_data_line(t_defect d);
        int n;
        int gap_at;
        int gap_n;
        int bad_at;
        n = HEX_CHARS;
        gap_at = -1;
        bad_at = -1;
        gap_n = 0;
        case (d)
            DEF_SHORT:       n = $urandom_range(1, HEX_CHARS - 1);
            DEF_LONG:        n = $urandom_range(HEX_CHARS + 1, HEX_CHARS + 8);
            DEF_OVERLONG:    n = $urandom_range(64, 80);
            DEF_LEN_AND_HEX: n = ($urandom_range(0, 1) == 0) ? $urandom_range(2, HEX_CHARS - 1)
                                 : $urandom_range(HEX_CHARS + 1, HEX_CHARS + 8);
            DEF_GAP: begin
                // blanks stand in for digits: right length, bad content
                gap_n = $urandom_range(1, 3);
                n = HEX_CHARS - gap_n;
                gap_at = $urandom_range(1, n - 1);
            end
            DEF_WIDE_GAP: begin
                gap_n = $urandom_range(64, 70);
                gap_at = n / 2;
            end
            default: ;
        endcase
        if (d == DEF_BAD_DIGIT || d == DEF_LEN_AND_HEX) bad_at = $urandom_range(0, n - 1);
        add_ws(4);
        for (int i = 0; i < n; i++) begin
            if (i == gap_at) repeat (gap_n) text_q.push_back(pick_ws());
            text_q.push_back((i == bad_at) ? pick_bad() : pick_hex());
        end
        add_ws(4);
        text_q.push_back(CH_LF);
    endfunction

    function automatic void add_table_file(int nlines, bit clean);
        t_defect d;
        repeat ($urandom_range(0, 2)) add_filler(1);
        add_header(!clean && $urandom_range(0, 9) == 0);
        for (int i = 0; i < nlines; i++) begin
            if ($urandom_range(0, 4) == 0) add_filler(0);
            d = DEF_NONE;
            if (!clean && $urandom_range(0, 11) == 0) d = t_defect'($urandom_range(1, 7));
            add_data_line(d);
        end
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) add_filler(1);
        if ($urandom_range(0, 1) == 0) void'(text_q.pop_back());
    endfunction

    function automatic void add_noise_file();
        repeat ($urandom_range(1, 24)) begin
            case ($urandom_range(0, 3))
                0:       text_q.push_back(pick_ws());
                1:       text_q.push_back(CH_LF);
                default: text_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    task automatic send_text();
        int n;
        n = text_q.size();
        for (int i = 0; i < n; i++) begin
            if (burst_left == 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                             : $urandom_range(1, 24);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= text_q[i];
            i_s_tlast  <= (i == n - 1);
            do @(posedge i_clk); while (!o_s_tready);
            sb.take_text(text_q[i], i == n - 1);
            burst_left--;
            beats_sent++;
        end
        text_q.delete();
    endtask

    initial begin
        int nlines;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // blank file, header at end of file, trimmed header then bad line,
        // top byte value, comment ended by a final LF
        text_q.push_back(8'h00);
        send_text();
        add_text("physics");
        send_text();
        text_q.push_back(CH_SPACE);
        add_text("physics");
        text_q.push_back(CH_SPACE);
        text_q.push_back(CH_LF);
        add_text("Z");
        send_text();
        text_q.push_back(8'hFF);
        send_text();
        text_q.push_back(CH_HASH);
        text_q.push_back(CH_LF);
        send_text();

        add_table_file($urandom_range(2, 4), 1'b1);
        send_text();
        while (beats_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 2) begin
                add_noise_file();
            end else begin
                nlines = $urandom_range(0, (ITEM_TARGET - beats_sent) / (HEX_CHARS + 8));
                add_table_file(nlines, 1'b0);
            end
            send_text();
        end
        i_s_tvalid <= 1'b0;

        while (sb.due_beats.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Covered %0d files in %0d text beats; %0d table bytes checked.",
                 sb.n_files, sb.n_text, sb.n_bytes);
        $display("Status beats: ok %0d, bad length %0d, bad hex %0d, no table %0d, short %0d.",
                 sb.n_status[ST_OK], sb.n_status[ST_BAD_LEN], sb.n_status[ST_BAD_HEX],
                 sb.n_status[ST_NO_TABLE], sb.n_status[ST_SHORT]);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/htp_pkg.sv
sv/htp_front.sv
sv/htp_queue.sv
sv/htp_back.sv
sv/hex_table_text_parser.sv
sv/htp_checker.sv
tb/tb.sv
